/* rtl/core/clock_writeback_cache_defines.svh */
// Assertion macros used by the cache RTL.
`ifndef CLOCK_WRITEBACK_CACHE_DEFINES_SVH
`define CLOCK_WRITEBACK_CACHE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define CWC_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Next-cycle implication checked on every rising clock edge outside reset.
`define CWC_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

/* rtl/core/cwc_pkg.sv */
package cwc_pkg;

   typedef enum logic [1:0] {
      OP_GET   = 2'd0,
      OP_SET   = 2'd1,
      OP_FILL  = 2'd2,
      OP_FLUSH = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_HIT       = 3'd0,
      KIND_FETCH     = 3'd1,
      KIND_WRITEBACK = 3'd2,
      KIND_ANSWER    = 3'd3,
      KIND_DONE      = 3'd4
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOKUP = 5'b00010,
      ST_SWEEP  = 5'b00100,
      ST_FLUSH  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

/* rtl/core/clock_writeback_cache.sv */
// Channel   | Ports                                             | Direction
// ----------+---------------------------------------------------+----------
// request   | start, busy, req_opcode, req_key, req_data_value, | in, busy out
//           | req_found                                         |
// response  | rsp_valid, rsp_kind, rsp_out_key, rsp_out_value,  | out
//           | rsp_out_found, rsp_last                           |
// config    | csr_write_enable, csr_write_data                  | in
//
// An item is accepted when start is high and busy is low; busy drops in the cycle
// that shows the final result of that item. A get, or a fill that was not found,
// ends in lookup; set and fill add finish and, with the pool full, a clock hand sweep
// (at most ENTRIES+1 hand steps); a flush walks each filled slot, at least one.
// Sweep and flush walk one slot a cycle; the lookup compares every key at once.
// Synchronous reset clears count, hand, reference and dirty bits, not keys or values.
// Each result stays one cycle under rsp_valid; the receiver cannot stall it.
`include "clock_writeback_cache_defines.svh"

module clock_writeback_cache #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  cwc_pkg::op_type       req_opcode,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [VALUE_BITS-1:0] req_data_value,
   input  logic                  req_found,
   input  logic                  csr_write_enable,
   input  logic [4:0]            csr_write_data,
   output logic                  rsp_valid,
   output cwc_pkg::kind_type     rsp_kind,
   output logic [KEY_BITS-1:0]   rsp_out_key,
   output logic [VALUE_BITS-1:0] rsp_out_value,
   output logic                  rsp_out_found,
   output logic                  rsp_last
);
   import cwc_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   // Slot storage; keys and values are never cleared.
   logic [KEY_BITS-1:0]   key_mem_ff   [ENTRIES];
   logic [VALUE_BITS-1:0] value_mem_ff [ENTRIES];
   logic [ENTRIES-1:0]    ref_ff, ref_in;
   logic [ENTRIES-1:0]    dirty_ff, dirty_in;
   logic [CW-1:0]         filled_ff, filled_in;
   logic [IW-1:0]         hand_ff, hand_in;
   logic [4:0]            cap_reg_ff;

   state_type             state_ff, state_in;
   op_type                op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] data_ff;
   logic                  found_ff;
   logic                  hit_ff, hit_in;
   logic [IW-1:0]         hit_idx_ff, hit_idx_in;
   logic [IW-1:0]         scan_ff, scan_in;

   logic                  wr_en;
   logic [IW-1:0]         wr_idx;

   logic                  rv_in, rl_in, rf_in;
   kind_type              rk_in;
   logic [KEY_BITS-1:0]   rkey_in;
   logic [VALUE_BITS-1:0] rval_in;

   // Capacity clamp to 1..ENTRIES.
   logic [CW-1:0] cap;
   always_comb begin
      if (cap_reg_ff == 5'd0) begin
         cap = CW'(1);
      end else if (32'(cap_reg_ff) > ENTRIES) begin
         cap = CW'(ENTRIES);
      end else begin
         cap = CW'(cap_reg_ff);
      end
   end

   // Parallel lookup among filled slots, lowest index wins.
   logic          look_hit;
   logic [IW-1:0] look_idx;
   always_comb begin
      look_hit = 1'b0;
      look_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if ((CW'(i) < filled_ff) && (key_mem_ff[i] == key_ff)) begin
            look_hit = 1'b1;
            look_idx = IW'(i);
         end
      end
   end

   logic [IW-1:0] hand_next;
   logic [IW-1:0] hand_eff;
   logic          sweep_place;
   always_comb begin
      hand_eff  = (CW'(hand_ff) >= cap) ? '0 : hand_ff;
      hand_next = (CW'(hand_eff) + CW'(1) >= cap) ? '0 : IW'(hand_eff + IW'(1));
   end

   always_comb begin
      state_in   = state_ff;
      ref_in     = ref_ff;
      dirty_in   = dirty_ff;
      filled_in  = filled_ff;
      hand_in    = hand_ff;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      scan_in    = scan_ff;
      wr_en      = 1'b0;
      wr_idx     = '0;
      rv_in      = 1'b0;
      rk_in      = KIND_DONE;
      rkey_in    = '0;
      rval_in    = '0;
      rf_in      = 1'b0;
      rl_in      = 1'b0;
      sweep_place = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_opcode == OP_FLUSH) ? ST_FLUSH : ST_LOOKUP;
               scan_in  = '0;
            end
         end
         ST_LOOKUP: begin
            hit_in     = look_hit;
            hit_idx_in = look_idx;
            state_in   = ST_FINISH;
            if (op_ff == OP_GET) begin
               rv_in   = 1'b1;
               rl_in   = 1'b1;
               rkey_in = key_ff;
               if (look_hit) begin
                  ref_in[look_idx] = 1'b1;
                  rk_in   = KIND_HIT;
                  rval_in = value_mem_ff[look_idx];
               end else begin
                  rk_in = KIND_FETCH;
               end
               state_in = ST_IDLE;
            end else if (op_ff == OP_FILL && !found_ff) begin
               rv_in   = 1'b1;
               rl_in   = 1'b1;
               rk_in   = KIND_ANSWER;
               rkey_in = key_ff;
               state_in = ST_IDLE;
            end else if (!look_hit) begin
               if (filled_ff < cap) begin
                  hit_idx_in = IW'(filled_ff);
                  filled_in  = filled_ff + CW'(1);
               end else begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            // One slot of the clock hand per cycle.
            if (ref_ff[hand_eff]) begin
               ref_in[hand_eff] = 1'b0;
               hand_in = hand_next;
            end else begin
               sweep_place = 1'b1;
               hit_idx_in  = hand_eff;
               hand_in     = hand_next;
               state_in    = ST_FINISH;
               if (dirty_ff[hand_eff]) begin
                  dirty_in[hand_eff] = 1'b0;
                  rv_in   = 1'b1;
                  rk_in   = KIND_WRITEBACK;
                  rkey_in = key_mem_ff[hand_eff];
                  rval_in = value_mem_ff[hand_eff];
               end
            end
         end
         ST_FLUSH: begin
            if (CW'(scan_ff) < filled_ff) begin
               if (dirty_ff[scan_ff]) begin
                  rv_in   = 1'b1;
                  rk_in   = KIND_WRITEBACK;
                  rkey_in = key_mem_ff[scan_ff];
                  rval_in = value_mem_ff[scan_ff];
               end
            end
            if ((CW'(scan_ff) + CW'(1) >= filled_ff) ||
                (CW'(scan_ff) + CW'(1) >= CW'(ENTRIES))) begin
               ref_in    = '0;
               dirty_in  = '0;
               filled_in = '0;
               hand_in   = '0;
               state_in  = ST_FINISH;
            end else begin
               scan_in = scan_ff + IW'(1);
            end
         end
         ST_FINISH: begin
            rv_in    = 1'b1;
            rl_in    = 1'b1;
            state_in = ST_IDLE;
            if (op_ff == OP_FLUSH) begin
               rk_in = KIND_DONE;
            end else if (op_ff == OP_SET) begin
               rk_in  = KIND_DONE;
               wr_en  = 1'b1;
               wr_idx = hit_idx_ff;
               dirty_in[hit_idx_ff] = 1'b1;
               if (hit_ff) begin
                  ref_in[hit_idx_ff] = 1'b1;
               end
            end else begin
               rk_in   = KIND_ANSWER;
               rkey_in = key_ff;
               rf_in   = 1'b1;
               ref_in[hit_idx_ff] = 1'b1;
               if (hit_ff) begin
                  rval_in = value_mem_ff[hit_idx_ff];
               end else begin
                  rval_in = data_ff;
                  wr_en   = 1'b1;
                  wr_idx  = hit_idx_ff;
                  dirty_in[hit_idx_ff] = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ref_ff     <= '0;
         dirty_ff   <= '0;
         filled_ff  <= '0;
         hand_ff    <= '0;
         cap_reg_ff <= 5'(ENTRIES);
         rsp_valid  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ref_ff     <= ref_in;
         dirty_ff   <= dirty_in;
         filled_ff  <= filled_in;
         hand_ff    <= hand_in;
         rsp_valid  <= rv_in;
         if (csr_write_enable) begin
            cap_reg_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      scan_ff       <= scan_in;
      rsp_kind      <= rk_in;
      rsp_out_key   <= rkey_in;
      rsp_out_value <= rval_in;
      rsp_out_found <= rf_in;
      rsp_last      <= rl_in;
      if (start && state_ff == ST_IDLE) begin
         op_ff    <= req_opcode;
         key_ff   <= req_key;
         data_ff  <= req_data_value;
         found_ff <= req_found;
      end
      if (wr_en) begin
         key_mem_ff[wr_idx]   <= key_ff;
         value_mem_ff[wr_idx] <= data_ff;
      end else if (state_ff == ST_FINISH && op_ff == OP_SET) begin
         value_mem_ff[wr_idx] <= data_ff;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // A placement by the sweep only happens once the pool is full.
   `CWC_ASSERT_IMP(a_sweep_full, clock, reset, sweep_place, filled_ff >= cap, "sweep with free slot")
   // The fill count never exceeds the slot count.
   `CWC_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, 32'(filled_ff) <= ENTRIES, "fill overflow")
   // The final response always returns the block to idle.
   `CWC_ASSERT_NEXT(a_last_idle, clock, reset, rv_in && rl_in, !busy, "last without idle")
   // No response while idle without a start.
   `CWC_ASSERT_NEXT(a_quiet, clock, reset, state_ff == ST_IDLE, !rsp_valid, "spurious response")

endmodule

/* bench/testbench.sv */
module testbench;
   import cwc_pkg::*;

   // The cache has this many slots; the capacity register is clamped to it.
   localparam int SLOTS = 16;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   // Request channel, configuration port and response channel.
   logic        start = 1'b0;
   logic        busy;
   op_type      req_opcode = OP_GET;
   logic [31:0] req_key = '0;
   logic [31:0] req_data_value = '0;
   logic        req_found = 1'b0;
   logic        csr_write_enable = 1'b0;
   logic [4:0]  csr_write_data = '0;
   logic        rsp_valid;
   kind_type    rsp_kind;
   logic [31:0] rsp_out_key;
   logic [31:0] rsp_out_value;
   logic        rsp_out_found;
   logic        rsp_last;

   clock_writeback_cache dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .req_data_value  (req_data_value),
      .req_found       (req_found),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_found   (rsp_out_found),
      .rsp_last        (rsp_last)
   );

   // The clock has a period of 10 time units.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One response as the cache should show it.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] key;
      logic [31:0] value;
      logic        found;
      logic        last;
   } cache_response_type;

   // Responses that the shadow cache has predicted and that have not yet been seen.
   cache_response_type awaited_responses[$];
   int error_count = 0;

   // Shadow copy of the cache contents. Only slots below shadow_filled are
   // ever looked at, which mirrors the valid count inside the block.
   logic [31:0] shadow_keys [SLOTS];
   logic [31:0] shadow_values [SLOTS];
   logic        shadow_referenced [SLOTS];
   logic        shadow_dirty [SLOTS];
   int          shadow_filled = 0;
   int          shadow_hand = 0;
   logic [4:0]  shadow_capacity_reg = 5'd16;

   // Pool of keys that random traffic draws from, so that hits and evictions
   // actually happen instead of every lookup missing.
   logic [31:0] key_pool [24];

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   task automatic expect_response(input kind_type kind, input logic [31:0] key,
                                  input logic [31:0] value, input logic found,
                                  input logic last);
      cache_response_type r;
      r.kind  = kind;
      r.key   = key;
      r.value = value;
      r.found = found;
      r.last  = last;
      awaited_responses.push_back(r);
   endtask

   // The register value 0 behaves as 1 and anything above the slot count as
   // the slot count.
   function automatic int effective_capacity();
      if (shadow_capacity_reg == 5'd0) return 1;
      if (shadow_capacity_reg > SLOTS) return SLOTS;
      return int'(shadow_capacity_reg);
   endfunction

   function automatic int find_key(input logic [31:0] key);
      for (int i = 0; i < shadow_filled; i++)
         if (shadow_keys[i] == key) return i;
      return -1;
   endfunction

   // Picks the slot that a new key goes into. While the cache is not full
   // the next free slot is taken; otherwise the hand sweeps, giving every
   // referenced slot a second chance, and stops on the first unreferenced one.
   // A dirty victim is written back before it is replaced.
   task automatic pick_slot_for_insert(output int slot);
      int cap;
      cap = effective_capacity();
      if (shadow_filled < cap) begin
         slot = shadow_filled;
         shadow_filled++;
         return;
      end
      if (shadow_hand >= cap) shadow_hand = 0;
      while (shadow_referenced[shadow_hand]) begin
         shadow_referenced[shadow_hand] = 1'b0;
         shadow_hand = (shadow_hand + 1) % cap;
      end
      slot = shadow_hand;
      if (shadow_dirty[slot]) begin
         expect_response(KIND_WRITEBACK, shadow_keys[slot], shadow_values[slot], 1'b0, 1'b0);
         shadow_dirty[slot] = 1'b0;
      end
      shadow_hand = (shadow_hand + 1) % cap;
   endtask

   // Applies one accepted item to the shadow cache and queues what it causes.
   task automatic predict_cache_item(input op_type op, input logic [31:0] key,
                                     input logic [31:0] value, input logic found);
      int hit;
      int slot;
      hit = find_key(key);
      case (op)
         OP_GET: begin
            if (hit >= 0) begin
               shadow_referenced[hit] = 1'b1;
               expect_response(KIND_HIT, key, shadow_values[hit], 1'b0, 1'b1);
            end else begin
               expect_response(KIND_FETCH, key, '0, 1'b0, 1'b1);
            end
         end
         OP_SET: begin
            if (hit >= 0) begin
               shadow_values[hit] = value;
               shadow_referenced[hit] = 1'b1;
               shadow_dirty[hit] = 1'b1;
            end else begin
               // A freshly inserted key by set keeps its reference bit clear.
               pick_slot_for_insert(slot);
               shadow_keys[slot] = key;
               shadow_values[slot] = value;
               shadow_dirty[slot] = 1'b1;
            end
            expect_response(KIND_DONE, '0, '0, 1'b0, 1'b1);
         end
         OP_FILL: begin
            if (!found) begin
               expect_response(KIND_ANSWER, key, '0, 1'b0, 1'b1);
            end else if (hit >= 0) begin
               // The cached copy wins over the value that the backing store sent.
               shadow_referenced[hit] = 1'b1;
               expect_response(KIND_ANSWER, key, shadow_values[hit], 1'b1, 1'b1);
            end else begin
               pick_slot_for_insert(slot);
               shadow_keys[slot] = key;
               shadow_values[slot] = value;
               shadow_dirty[slot] = 1'b0;
               shadow_referenced[slot] = 1'b1;
               expect_response(KIND_ANSWER, key, value, 1'b1, 1'b1);
            end
         end
         default: begin
            for (int i = 0; i < shadow_filled; i++)
               if (shadow_dirty[i])
                  expect_response(KIND_WRITEBACK, shadow_keys[i], shadow_values[i],
                                  1'b0, 1'b0);
            for (int i = 0; i < SLOTS; i++) begin
               shadow_referenced[i] = 1'b0;
               shadow_dirty[i] = 1'b0;
            end
            shadow_filled = 0;
            shadow_hand = 0;
            expect_response(KIND_DONE, '0, '0, 1'b0, 1'b1);
         end
      endcase
   endtask

   // Sends one item. It is called just after a rising edge and returns just
   // after the edge that accepted the item, with start still high, so that a
   // following call can present the next item without a gap.
   task automatic send_item(input op_type op, input logic [31:0] key,
                            input logic [31:0] value, input logic found);
      start          <= 1'b1;
      req_opcode     <= op;
      req_key        <= key;
      req_data_value <= value;
      req_found      <= found;
      do @(posedge clock); while (busy);
      predict_cache_item(op, key, value, found);
   endtask

   // Holds the request channel quiet for a number of cycles.
   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Waits until every predicted response has been seen and the block has
   // had time to settle back to idle.
   task automatic drain_responses();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (awaited_responses.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   // Writes the capacity register. Only done while the cache is idle.
   task automatic write_capacity(input logic [4:0] value);
      drain_responses();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_capacity_reg = value;
      @(posedge clock);
   endtask

   // Every response is compared with the oldest prediction. Inputs and outputs
   // are sampled at the rising edge, before the block's own updates land.
   always @(posedge clock) begin
      cache_response_type exp_r;
      if (!reset && rsp_valid) begin
         if (awaited_responses.size() == 0) begin
            report_mismatch($sformatf("response kind %0d with nothing expected",
                                      rsp_kind));
         end else begin
            exp_r = awaited_responses.pop_front();
            if (rsp_kind !== exp_r.kind)
               report_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, exp_r.kind));
            if (rsp_out_key !== exp_r.key)
               report_mismatch($sformatf("key %h, expected %h", rsp_out_key, exp_r.key));
            if (rsp_out_value !== exp_r.value)
               report_mismatch($sformatf("value %h, expected %h",
                                         rsp_out_value, exp_r.value));
            if (rsp_out_found !== exp_r.found)
               report_mismatch($sformatf("found %b, expected %b",
                                         rsp_out_found, exp_r.found));
            if (rsp_last !== exp_r.last)
               report_mismatch($sformatf("last %b, expected %b", rsp_last, exp_r.last));
         end
      end
   end

   // Basic operations at the extremes of the key and value ranges: a miss,
   // the fill that answers it, a hit, a set over a cached entry, a fill of a
   // key already cached (the cached value must win), a fill that the backing
   // store could not serve, and flushes with and without dirty entries.
   task automatic test_basic_operations();
      send_item(OP_GET,   32'h0000_0000, 32'h1234_5678, 1'b1);
      send_item(OP_FILL,  32'h0000_0000, 32'hffff_ffff, 1'b1);
      send_item(OP_GET,   32'h0000_0000, 32'h0000_0000, 1'b0);
      send_item(OP_SET,   32'hffff_ffff, 32'h0000_0000, 1'b0);
      send_item(OP_FILL,  32'hffff_ffff, 32'haaaa_5555, 1'b1);
      send_item(OP_FILL,  32'h5555_aaaa, 32'hffff_ffff, 1'b0);
      send_item(OP_SET,   32'h0000_0000, 32'h8000_0001, 1'b1);
      send_item(OP_GET,   32'hffff_ffff, 32'hffff_ffff, 1'b1);
      send_item(OP_FLUSH, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
      send_item(OP_FLUSH, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_item(OP_GET,   32'h0000_0000, 32'h0000_0000, 1'b0);
   endtask

   // Small capacities force the clock sweep: a dirty victim gets written back,
   // a referenced slot gets a second chance, then the capacity is dropped
   // below the number of valid slots, so that the sweep runs within the lower slots.
   // The out-of-range register values 0 and 31 are tried as well.
   task automatic test_capacity_limits();
      write_capacity(5'd2);
      send_item(OP_SET,  32'h0000_0011, 32'h0000_0001, 1'b0);
      send_item(OP_FILL, 32'h0000_0022, 32'h0000_0002, 1'b1);
      send_item(OP_SET,  32'h0000_0033, 32'h0000_0003, 1'b0);
      send_item(OP_GET,  32'h0000_0022, 32'h0000_0000, 1'b0);
      send_item(OP_FILL, 32'h0000_0044, 32'h0000_0004, 1'b1);
      write_capacity(5'd1);
      send_item(OP_SET,  32'h0000_0055, 32'h0000_0005, 1'b0);
      send_item(OP_GET,  32'h0000_0044, 32'h0000_0000, 1'b0);
      send_item(OP_GET,  32'h0000_0033, 32'h0000_0000, 1'b0);
      write_capacity(5'd0);
      send_item(OP_SET,  32'h0000_0066, 32'h0000_0006, 1'b0);
      send_item(OP_FILL, 32'h0000_0077, 32'h0000_0007, 1'b1);
      send_item(OP_FLUSH, 32'h0, 32'h0, 1'b0);
      write_capacity(5'd31);
      for (int i = 0; i < 18; i++)
         send_item(OP_SET, 32'h100 + i, 32'hf000_0000 + i, 1'b0);
      send_item(OP_FLUSH, 32'h0, 32'h0, 1'b0);
   endtask

   // Random traffic at a given capacity and sender idle rate. Most keys come
   // from a small pool so that hits, refills and evictions are common; now
   // and then a fully random key is used. A miss is usually followed by its
   // fill, the way a backing store would answer it.
   task automatic test_random_traffic(input int count, input logic [4:0] capacity,
                                      input int idle_percent);
      int          pick;
      op_type      op;
      logic [31:0] key;
      logic        found;
      write_capacity(capacity);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < idle_percent) idle_cycles($urandom_range(1, 6));
         key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(23)];
         pick = $urandom_range(99);
         if (pick < 35)      op = OP_GET;
         else if (pick < 65) op = OP_SET;
         else if (pick < 95) op = OP_FILL;
         else                op = OP_FLUSH;
         found = ($urandom_range(4) != 0);
         send_item(op, key, $urandom, found);
         if (op == OP_GET && find_key(key) < 0 && $urandom_range(3) != 0) begin
            if ($urandom_range(99) < idle_percent) idle_cycles($urandom_range(1, 6));
            send_item(OP_FILL, key, $urandom, found);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
      // After reset every reference and dirty bit is clear.
      for (int i = 0; i < SLOTS; i++) begin
         shadow_referenced[i] = 1'b0;
         shadow_dirty[i] = 1'b0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_operations();
      test_capacity_limits();
      // Sender idles now and then, then often, then never; capacity moves between
      // full size and small values so the sweep wraps at different places.
      test_random_traffic(60, 5'd16, 37);
      test_random_traffic(50, 5'd3, 37);
      test_random_traffic(60, 5'd8, 78);
      test_random_traffic(40, 5'd1, 78);
      test_random_traffic(60, 5'd16, 0);
      test_random_traffic(40, 5'd5, 0);

      drain_responses();
      if (awaited_responses.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", awaited_responses.size()));
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog against a hang anywhere in the run.
   initial begin
      #5000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/cwc_pkg.sv
rtl/core/clock_writeback_cache.sv
bench/testbench.sv
